// ===== rtl/bra_pkg.sv =====
package bra_pkg;

  // Field widths of the stream beats and the config register
  localparam int unsigned OpW      = 2;
  localparam int unsigned BitIdxW  = 9;
  localparam int unsigned RunLenW  = 10;
  localparam int unsigned StartW   = 9;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ByteSelW = BitIdxW - 3;
  localparam int unsigned BiuW     = 7;

  // Bitmap size and config reset value
  localparam int unsigned MaxBytesDef = 64;
  localparam logic [BiuW-1:0] BiuReset = 7'd64;

  // Operation codes carried in the input tuser
  typedef enum logic [OpW-1:0] {
    OP_TEST  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/bra_ram.sv =====
module bra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bitmap_run_allocator_core.sv =====
// Channel      Dir  Fields (low bit first)                         Handshake
// s_axis       in   tdata: bit_index[8:0], run_length[18:9]        tvalid/tready
//                   tuser: opcode[1:0]
// m_axis       out  tdata: bit_value[0], start_index[9:1]          tvalid/tready
//                   tuser: found[0]
// cfg          in   cfg_wdata_i: bytes_in_use[6:0]                 cfg_we_i
//
// An in-range test, set or clear takes a RAM read, a modify/write step and a result step.
// A scan reads at most min(bytes_in_use, MAX_BYTES) map bytes, one byte per cycle, and stops
// at the first fitting run; a scan of length zero or beyond that limit skips the reads.
// After reset a clearing pass writes zero to all MAX_BYTES entries, one per cycle, with
// s_axis_tready low; config writes are taken during it.
// One item is in flight at a time; a held result stalls the sequencer, not the output.
module bitmap_run_allocator_core #(
  parameter int unsigned MAX_BYTES = bra_pkg::MaxBytesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Config register
  input  logic                                 cfg_we_i,
  input  logic [bra_pkg::BiuW-1:0]             cfg_wdata_i,    // bytes_in_use
  // Request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [23:0]                          s_axis_tdata,   // bit_index, run_length
  input  logic [bra_pkg::OpW-1:0]              s_axis_tuser,   // opcode
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,   // bit_value, start_index
  output logic [0:0]                           m_axis_tuser    // found
);

  import bra_pkg::*;

  localparam int unsigned AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned NBW = AW + 1;
  localparam int unsigned BW  = (BiuW > NBW) ? BiuW : NBW;
  localparam int unsigned LW  = (RunLenW > NBW + 3) ? RunLenW : NBW + 3;
  localparam int unsigned CW  = ((AW + 3 > RunLenW) ? AW + 3 : RunLenW) + 1;

  state_e state_q, state_d;

  logic [BiuW-1:0]    biu_q;
  logic [AW-1:0]      clr_q, clr_d;
  op_e                op_q, op_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [2:0]         bit_q, bit_d;
  logic [RunLenW-1:0] want_q, want_d;
  logic [NBW-1:0]     nb_q, nb_d;
  logic [NBW-1:0]     issue_q, issue_d;
  logic [NBW-1:0]     db_q, db_d;
  logic               dv_q, dv_d;
  logic [RunLenW-1:0] run_q, run_d;
  logic               res_bit_q, res_bit_d;
  logic               res_found_q, res_found_d;
  logic [StartW-1:0]  res_start_q, res_start_d;
  logic               m_valid_q, m_valid_d;
  logic               m_bit_q;
  logic               m_found_q;
  logic [StartW-1:0]  m_start_q;
  logic               out_load;

  // RAM port signals
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ByteW-1:0]   ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ByteW-1:0]   ram_wdata;

  // Request decode
  op_e                in_op;
  logic [BitIdxW-1:0] in_idx;
  logic [RunLenW-1:0] in_len;
  logic [AW+5:0]      in_byte_ext;
  logic               in_range;
  logic [AW-1:0]      in_addr;
  logic [BW-1:0]      biu_ext;
  logic [NBW-1:0]     nb_now;
  logic [LW-1:0]      limit_now;
  logic               scan_miss;

  // Byte walk
  logic [RunLenW-1:0] run_v;
  logic               hit_v;
  logic [2:0]         pos_v;
  logic [CW-1:0]      start_v;

  assign in_op       = op_e'(s_axis_tuser);
  assign in_idx      = s_axis_tdata[BitIdxW-1:0];
  assign in_len      = s_axis_tdata[BitIdxW+RunLenW-1:BitIdxW];
  assign in_byte_ext = {{AW{1'b0}}, in_idx[BitIdxW-1:3]};
  assign in_range    = in_byte_ext < (AW + 6)'(MAX_BYTES);
  assign in_addr     = in_byte_ext[AW-1:0];

  // Saturate the scan limit at the map size
  assign biu_ext   = BW'(biu_q);
  assign nb_now    = (biu_ext > BW'(MAX_BYTES)) ? NBW'(MAX_BYTES) : NBW'(biu_ext);
  assign limit_now = LW'(nb_now) << 3;
  assign scan_miss = (in_len == '0) || (LW'(in_len) > limit_now);

  // Walk the eight bits of one map byte, LSB first
  always_comb begin
    run_v = run_q;
    hit_v = 1'b0;
    pos_v = '0;
    for (int k = 0; k < ByteW; k++) begin
      if (!hit_v) begin
        if (ram_rdata[k]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 1'b1;
        end
        if (run_v == want_q) begin
          hit_v = 1'b1;
          pos_v = 3'(k);
        end
      end
    end
  end

  assign start_v = CW'({db_q[AW-1:0], pos_v}) + CW'(1) - CW'(want_q);

  // Map storage
  bra_ram #(
    .Width (ByteW),
    .Depth (MAX_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= BiuReset;
    end else if (cfg_we_i) begin
      biu_q <= cfg_wdata_i;
    end
  end

  // State register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      dv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      dv_q      <= dv_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    bit_q       <= bit_d;
    want_q      <= want_d;
    nb_q        <= nb_d;
    issue_q     <= issue_d;
    db_q        <= db_d;
    run_q       <= run_d;
    res_bit_q   <= res_bit_d;
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    if (out_load) begin
      m_bit_q   <= res_bit_q;
      m_found_q <= res_found_q;
      m_start_q <= res_start_q;
    end
  end

  // Next state, RAM control and result capture
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    op_d          = op_q;
    addr_d        = addr_q;
    bit_d         = bit_q;
    want_d        = want_q;
    nb_d          = nb_q;
    issue_d       = issue_q;
    db_d          = db_q;
    dv_d          = 1'b0;
    run_d         = run_q;
    res_bit_d     = res_bit_q;
    res_found_d   = res_found_q;
    res_start_d   = res_start_q;
    ram_re        = 1'b0;
    ram_raddr     = addr_q;
    ram_we        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = ram_rdata;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one entry per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(MAX_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d        = in_op;
          addr_d      = in_addr;
          bit_d       = in_idx[2:0];
          want_d      = in_len;
          nb_d        = nb_now;
          issue_d     = '0;
          run_d       = '0;
          res_bit_d   = 1'b0;
          res_found_d = 1'b0;
          res_start_d = '0;
          if (in_op == OP_SCAN) begin
            state_d = scan_miss ? ST_RESP : ST_SCAN;
          end else if (in_range) begin
            ram_re    = 1'b1;
            ram_raddr = in_addr;
            state_d   = ST_ACCESS;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_ACCESS: begin
        // Read data is here: report or modify and write back
        unique case (op_q)
          OP_TEST: begin
            res_bit_d = ram_rdata[bit_q];
          end
          OP_SET: begin
            ram_we             = 1'b1;
            ram_wdata[bit_q]   = 1'b1;
          end
          OP_CLEAR: begin
            ram_we             = 1'b1;
            ram_wdata[bit_q]   = 1'b0;
          end
          OP_SCAN: begin
            res_bit_d = 1'b0;
          end
        endcase
        state_d = ST_RESP;
      end

      ST_SCAN: begin
        // Issue the next byte read
        if (issue_q < nb_q) begin
          ram_re    = 1'b1;
          ram_raddr = issue_q[AW-1:0];
          issue_d   = issue_q + 1'b1;
          db_d      = issue_q;
          dv_d      = 1'b1;
        end
        // Consume the byte read last cycle
        if (dv_q) begin
          run_d = run_v;
          if (hit_v) begin
            res_found_d = 1'b1;
            res_start_d = start_v[StartW-1:0];
            dv_d        = 1'b0;
            state_d     = ST_RESP;
          end else if (db_q == nb_q - 1'b1) begin
            dv_d    = 1'b0;
            state_d = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: hold until the beat is taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_start_q, m_bit_q};
  assign m_axis_tuser  = m_found_q;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during map clearing pass");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_ACCESS))
    else $error("map written outside clear or read-modify-write");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && dv_q) |-> (db_q < nb_q))
    else $error("scan walked past the byte limit");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_RESP))
    else $error("result beat raised without a finished item");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  import bra_pkg::*;

  localparam int unsigned NumPhases    = 10;
  localparam int unsigned ItemsPerPhase = 48;
  localparam int unsigned LongHoldLen  = 300;
  localparam int unsigned WatchdogLim  = 3000;

  typedef struct packed {
    op_e              op;
    logic [BitIdxW-1:0] bit_index;
    logic [RunLenW-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic              bit_value;
    logic              found;
    logic [StartW-1:0] start_index;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            cfg_we_i      = 1'b0;
  logic [BiuW-1:0] cfg_wdata_i   = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata  = '0;   // bit_index[8:0], run_length[18:9]
  logic [OpW-1:0]  s_axis_tuser  = '0;   // opcode[1:0]
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;         // bit_value[0], start_index[9:1]
  logic [0:0]      m_axis_tuser;         // found[0]

  bitmap_run_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Local copy of the allocation map and the map size register
  logic [MaxBytesDef*ByteW-1:0] map_bits  = '0;
  logic [BiuW-1:0]              map_bytes = BiuReset;

  req_t   request_q[$];
  reply_t reply_q[$];

  int unsigned issued        = 0;
  int unsigned replies_seen  = 0;
  int unsigned runs_found    = 0;
  int unsigned err_cnt       = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  logic        req_taken     = 1'b0;
  logic        long_hold_req = 1'b0;

  logic [BiuW-1:0] map_sizes [NumPhases] =
    '{7'd1, 7'd0, 7'd127, 7'd65, 7'd13, 7'd64, 7'd100, 7'd32, 7'd7, 7'd40};

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one request to the local map and return the answer it produces
  function automatic reply_t apply_request(req_t rq);
    reply_t      rp;
    int unsigned span;
    int unsigned run;
    rp = '0;
    span = ((map_bytes > MaxBytesDef) ? MaxBytesDef : map_bytes) * ByteW;
    case (rq.op)
      OP_TEST:  rp.bit_value = map_bits[rq.bit_index];
      OP_SET:   map_bits[rq.bit_index] = 1'b1;
      OP_CLEAR: map_bits[rq.bit_index] = 1'b0;
      default: begin
        // First fit: lowest start of a free run lying wholly inside the limit
        if (rq.run_length != 0 && rq.run_length <= span) begin
          run = 0;
          for (int unsigned b = 0; b < span; b++) begin
            run = map_bits[b] ? 0 : run + 1;
            if (!rp.found && run == rq.run_length) begin
              rp.found       = 1'b1;
              rp.start_index = StartW'(b + 1 - run);
            end
          end
        end
      end
    endcase
    return rp;
  endfunction

  function automatic req_t random_request(int unsigned span);
    req_t        rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    rq.op = (pick < 35) ? OP_SET : (pick < 60) ? OP_CLEAR : (pick < 75) ? OP_TEST : OP_SCAN;
    if ($urandom_range(0, 4) == 0) rq.bit_index = BitIdxW'($urandom_range(0, 511));
    else                           rq.bit_index = BitIdxW'($urandom_range(0, span - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0)     rq.run_length = RunLenW'($urandom_range(0, 1023));
    else if (pick < 4) rq.run_length = RunLenW'($urandom_range(1, span));
    else               rq.run_length = RunLenW'($urandom_range(1, 16));
    return rq;
  endfunction

  task automatic issue(op_e op, int unsigned idx, int unsigned len);
    req_t rq;
    rq.op         = op;
    rq.bit_index  = BitIdxW'(idx);
    rq.run_length = RunLenW'(len);
    request_q.push_back(rq);
    issued++;
  endtask

  // Free a random stretch of bits, fence it with a used bit, then ask for it
  task automatic issue_free_run(int unsigned span);
    int unsigned len;
    int unsigned first;
    len   = $urandom_range(1, (span < 12) ? span : 12);
    first = $urandom_range(0, span - len);
    if (first > 0) issue(OP_SET, first - 1, 0);
    for (int unsigned k = 0; k < len; k++) issue(OP_CLEAR, first + k, $urandom_range(0, 1023));
    issue(OP_SCAN, $urandom_range(0, 511), len);
    if ($urandom_range(0, 1)) issue(OP_TEST, first, 0);
  endtask

  // Mark a random stretch of bits used to make the map dense
  task automatic issue_fill(int unsigned span);
    int unsigned len;
    int unsigned first;
    len   = $urandom_range(1, (span < 16) ? span : 16);
    first = $urandom_range(0, span - len);
    for (int unsigned k = 0; k < len; k++) issue(OP_SET, first + k, $urandom_range(0, 1023));
  endtask

  task automatic drain();
    while (request_q.size() != 0 || reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_map_size(logic [BiuW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    map_bytes = val;
  endtask

  // Request driver: hold a beat until taken, insert idle bursts between beats
  always @(negedge clk_i) begin : req_driver
    logic nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (req_taken) begin
      void'(request_q.pop_front());
      nxt_valid = 1'b0;
    end
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (request_q.size() != 0) begin
        if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(0, 16);
        else nxt_valid = 1'b1;
      end
    end
    s_axis_tvalid <= nxt_valid;
    if (nxt_valid) begin
      s_axis_tdata <= {5'b0, request_q[0].run_length, request_q[0].bit_index};
      s_axis_tuser <= request_q[0].op;
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request
  always @(negedge clk_i) begin : rsp_receiver
    logic rdy;
    rdy = 1'b0;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      recv_stall    = LongHoldLen;
    end
    if (recv_stall > 0) begin
      recv_stall--;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_stall = $urandom_range(0, 16);
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  // Predict on each taken request, check each taken result, watch for hangs
  always @(posedge clk_i) begin : monitor
    req_t   rq;
    reply_t got;
    reply_t want;
    logic   rsp_taken;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    rsp_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (req_taken) begin
      rq.op         = op_e'(s_axis_tuser);
      rq.bit_index  = s_axis_tdata[8:0];
      rq.run_length = s_axis_tdata[18:9];
      reply_q.push_back(apply_request(rq));
    end
    if (rsp_taken) begin
      got.bit_value   = m_axis_tdata[0];
      got.start_index = m_axis_tdata[9:1];
      got.found       = m_axis_tuser[0];
      replies_seen++;
      if (got.found) runs_found++;
      if (reply_q.size() == 0) begin
        $error("result beat with no request outstanding");
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (got.bit_value !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
          err_cnt++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          err_cnt++;
        end
        if (got.start_index !== want.start_index) begin
          $error("start_index: expected %0d, got %0d", want.start_index, got.start_index);
          err_cnt++;
        end
      end
    end
    if (req_taken || rsp_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLim) begin
      $display("timeout: no beat moved for %0d cycles", idle_cycles);
      $display("bitmap_run_allocator_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned span;
    int unsigned target;
    int unsigned pick;
    logic        mid_drained;
    mid_drained = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every operation, zero and oversize runs
    send_idle_pct = 10;
    recv_idle_pct = 10;
    issue(OP_TEST, 0, 0);
    issue(OP_SET, 0, 1023);
    issue(OP_SET, 511, 0);
    issue(OP_TEST, 0, 0);
    issue(OP_TEST, 511, 1023);
    issue(OP_SCAN, 0, 0);
    issue(OP_SCAN, 511, 1);
    issue(OP_SCAN, 0, 510);
    issue(OP_SCAN, 0, 511);
    issue(OP_SCAN, 0, 512);
    issue(OP_SCAN, 0, 513);
    issue(OP_SCAN, 0, 1023);
    issue(OP_CLEAR, 0, 0);
    issue(OP_SCAN, 0, 511);
    issue(OP_CLEAR, 511, 0);
    issue(OP_SCAN, 0, 512);
    issue(OP_SET, 'h155, 'h2aa);
    issue(OP_SET, 'h0aa, 'h155);
    issue(OP_TEST, 'h155, 0);
    issue(OP_TEST, 'h0aa, 0);
    issue(OP_SCAN, 0, 170);
    issue(OP_SCAN, 0, 171);
    issue(OP_CLEAR, 'h155, 0);
    issue(OP_CLEAR, 'h0aa, 0);
    issue(OP_SCAN, 0, 512);
    drain();

    // Random phases, each under its own map size
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_map_size(map_sizes[p]);
      span = ((map_bytes > MaxBytesDef) ? MaxBytesDef : map_bytes) * ByteW;
      if (span == 0) span = ByteW;
      if (p == 4 || p == NumPhases - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(5, 30);
        recv_idle_pct = $urandom_range(5, 30);
      end
      // Back up the block behind a long result stall
      if (p == 2) long_hold_req = 1'b1;
      target = issued + ItemsPerPhase;
      while (issued < target) begin
        // Let the block empty out once in the middle of a phase
        if (p == 6 && !mid_drained && issued >= target - ItemsPerPhase / 2) begin
          mid_drained = 1'b1;
          drain();
        end
        pick = $urandom_range(0, 99);
        if (pick < 20)      issue_free_run(span);
        else if (pick < 30) issue_fill(span);
        else begin
          request_q.push_back(random_request(span));
          issued++;
        end
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    $display("covered %0d requests over %0d map sizes including 0 and 127",
             replies_seen, NumPhases + 1);
    $display("%0d scans found a free run, %0d mismatches", runs_found, err_cnt);
    if (err_cnt == 0) begin
      $display("bitmap_run_allocator_core test passed");
    end else begin
      $display("bitmap_run_allocator_core test failed");
    end
    $finish;
  end

endmodule
